@@ hw/rtl/sha256_stream_hasher_top_defines.svh @@
// assertion macros for the hasher
`ifndef SHA256_STREAM_HASHER_TOP_DEFINES_SVH
`define SHA256_STREAM_HASHER_TOP_DEFINES_SVH
`define SHA_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("hasher port property failed");
`define SHA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("hasher port sequence property failed");
`endif

@@ hw/rtl/sha_pkg.sv @@
package sha_pkg;
	localparam logic [31:0] H_INIT [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
	localparam logic [7:0] PAD_BYTE = 8'h80;

	typedef enum logic [1:0] {
		BYTE_DATA = 2'd0,
		BYTE_PAD = 2'd1,
		BYTE_ZERO = 2'd2,
		BYTE_LEN = 2'd3
	} byte_sel_t;

	typedef struct packed {
		logic wr_en;
		byte_sel_t wr_sel;
		logic count_bits;
		logic rnd_start;
		logic rnd_step;
		logic rnd_finish;
		logic msg_init;
		logic out_shift;
	} sha_cmd_t;

	typedef struct packed {
		logic [5:0] fill;
		logic [5:0] rnd;
	} sha_sts_t;
endpackage

@@ hw/rtl/sha_datapath.sv @@
module sha_datapath (
	input logic clk,
	input logic arst_n,
	input sha_pkg::sha_cmd_t cmd,
	input logic [7:0] data_byte,
	output sha_pkg::sha_sts_t sts,
	output logic [31:0] digest_word
);
	import sha_pkg::*;

	logic [31:0] blk_q [16];
	logic [5:0] fill_q;
	logic [63:0] bits_q;
	logic [31:0] h_q [8];
	logic [31:0] v_q [8];
	logic [31:0] w_q [16];
	logic [5:0] rnd_q;
	logic [7:0] wr_byte;
	logic [31:0] w_new, w_cur, s0, s1, sum0, sum1, ch, maj, p, q;

	always_comb begin
		unique case (cmd.wr_sel)
			BYTE_DATA: wr_byte = data_byte;
			BYTE_PAD: wr_byte = PAD_BYTE;
			BYTE_ZERO: wr_byte = 8'h00;
			BYTE_LEN: wr_byte = bits_q[{3'd7 - fill_q[2:0], 3'b000} +: 8];
			default: wr_byte = 8'h00;
		endcase
	end

	// block held as big-endian words, one byte lane written per cycle
	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			blk_q[fill_q[5:2]][{2'd3 - fill_q[1:0], 3'b000} +: 8] <= wr_byte;
		end
	end

	always_comb begin
		s0 = {w_q[1][6:0], w_q[1][31:7]} ^ {w_q[1][17:0], w_q[1][31:18]} ^ (w_q[1] >> 3);
		s1 = {w_q[14][16:0], w_q[14][31:17]} ^ {w_q[14][18:0], w_q[14][31:19]}
			^ (w_q[14] >> 10);
		w_new = s1 + w_q[9] + s0 + w_q[0];
		w_cur = w_q[0];
		sum1 = {v_q[4][5:0], v_q[4][31:6]} ^ {v_q[4][10:0], v_q[4][31:11]}
			^ {v_q[4][24:0], v_q[4][31:25]};
		ch = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		sum0 = {v_q[0][1:0], v_q[0][31:2]} ^ {v_q[0][12:0], v_q[0][31:13]}
			^ {v_q[0][21:0], v_q[0][31:22]};
		maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		p = v_q[7] + sum1 + ch + ROUND_K[rnd_q] + w_cur;
		q = sum0 + maj;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			bits_q <= '0;
			rnd_q <= '0;
			for (int i = 0; i < 8; i++) begin
				h_q[i] <= H_INIT[i];
			end
		end else begin
			if (cmd.wr_en) begin
				fill_q <= fill_q + 6'd1;
			end
			if (cmd.count_bits) begin
				bits_q <= bits_q + 64'd8;
			end
			if (cmd.rnd_start) begin
				rnd_q <= '0;
			end else if (cmd.rnd_step) begin
				rnd_q <= rnd_q + 6'd1;
			end
			if (cmd.rnd_finish) begin
				for (int i = 0; i < 8; i++) begin
					h_q[i] <= h_q[i] + v_q[i];
				end
			end else if (cmd.msg_init) begin
				for (int i = 0; i < 8; i++) begin
					h_q[i] <= H_INIT[i];
				end
				fill_q <= '0;
				bits_q <= '0;
			end else if (cmd.out_shift) begin
				for (int i = 0; i < 7; i++) begin
					h_q[i] <= h_q[i+1];
				end
				h_q[7] <= h_q[0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rnd_start) begin
			for (int i = 0; i < 8; i++) begin
				v_q[i] <= h_q[i];
			end
			for (int i = 0; i < 16; i++) begin
				w_q[i] <= blk_q[i];
			end
		end else if (cmd.rnd_step) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + p;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= p + q;
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[15] <= w_new;
		end
	end

	assign sts.fill = fill_q;
	assign sts.rnd = rnd_q;
	assign digest_word = h_q[0];
endmodule

@@ hw/rtl/sha_ctrl.sv @@
module sha_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic has_byte,
	input logic is_last,
	output logic out_valid,
	input logic out_ready,
	output logic [2:0] word_index,
	output logic last_word,
	input sha_pkg::sha_sts_t sts,
	output sha_pkg::sha_cmd_t cmd
);
	import sha_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RUN = 3'd1;
	localparam logic [2:0] ST_FIN = 3'd2;
	localparam logic [2:0] ST_PAD = 3'd3;
	localparam logic [2:0] ST_OUT = 3'd4;
	localparam logic [2:0] ST_ADD = 3'd5;

	logic [2:0] state_q, state_d;
	logic pad_q, pad_d;
	logic ext_q, ext_d;
	logic len_q, len_d;
	logic last_q, last_d;
	logic [2:0] idx_q;
	logic acc;

	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign word_index = idx_q;
	assign last_word = (idx_q == 3'd7);
	assign acc = in_valid && in_ready;

	always_comb begin
		cmd = '0;
		cmd.wr_sel = BYTE_DATA;
		state_d = state_q;
		pad_d = pad_q;
		ext_d = ext_q;
		len_d = len_q;
		last_d = last_q;
		unique case (state_q)
			ST_IDLE: begin
				if (acc) begin
					cmd.wr_en = has_byte;
					cmd.count_bits = has_byte;
					pad_d = 1'b0;
					ext_d = 1'b0;
					len_d = 1'b0;
					last_d = is_last;
					if (has_byte && sts.fill == 6'd63) begin
						state_d = ST_FIN;
					end else if (is_last) begin
						state_d = ST_PAD;
					end
				end
			end
			ST_FIN: begin
				cmd.rnd_start = 1'b1;
				state_d = ST_RUN;
			end
			ST_RUN: begin
				cmd.rnd_step = 1'b1;
				if (sts.rnd == 6'd63) begin
					state_d = ST_ADD;
				end
			end
			ST_ADD: begin
				cmd.rnd_finish = 1'b1;
				ext_d = 1'b0;
				if (!last_q) begin
					state_d = ST_IDLE;
				end else if (len_q) begin
					state_d = ST_OUT;
				end else begin
					state_d = ST_PAD;
				end
			end
			ST_PAD: begin
				cmd.wr_en = 1'b1;
				if (!pad_q) begin
					cmd.wr_sel = BYTE_PAD;
					pad_d = 1'b1;
					// pad byte past the length slot needs one more block
					if (sts.fill >= 6'd56) begin
						ext_d = 1'b1;
					end
				end else if (sts.fill >= 6'd56 && !ext_q) begin
					cmd.wr_sel = BYTE_LEN;
					if (sts.fill == 6'd63) begin
						len_d = 1'b1;
					end
				end else begin
					cmd.wr_sel = BYTE_ZERO;
				end
				if (sts.fill == 6'd63) begin
					state_d = ST_FIN;
				end
			end
			ST_OUT: begin
				if (out_ready) begin
					if (idx_q == 3'd7) begin
						cmd.msg_init = 1'b1;
						state_d = ST_IDLE;
					end else begin
						cmd.out_shift = 1'b1;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pad_q <= 1'b0;
			ext_q <= 1'b0;
			len_q <= 1'b0;
			last_q <= 1'b0;
			idx_q <= '0;
		end else begin
			state_q <= state_d;
			pad_q <= pad_d;
			ext_q <= ext_d;
			len_q <= len_d;
			last_q <= last_d;
			if (state_q == ST_OUT && out_ready) begin
				idx_q <= idx_q + 3'd1;
			end
		end
	end
endmodule

@@ hw/rtl/sha256_stream_hasher_top.sv @@
// sha-256 over a byte stream, at most one byte per transaction
// a data byte is taken while idle; a full block adds the compression rounds, with in_ready low
// message end: pad sweep to 64 bytes plus one or two compressions
// then eight digest transactions, one per cycle when out_ready is high
// arst_n restores the initial hash, clears counts; buffer is not cleared
module sha256_stream_hasher_top (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [7:0] data_byte,
	input logic has_byte,
	input logic is_last,
	output logic out_valid,
	input logic out_ready,
	output logic [31:0] digest_word,
	output logic [2:0] word_index,
	output logic last_word
);
	import sha_pkg::*;

	sha_cmd_t cmd;
	sha_sts_t sts;

	sha_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.has_byte(has_byte), .is_last(is_last), .out_valid(out_valid),
		.out_ready(out_ready), .word_index(word_index), .last_word(last_word),
		.sts(sts), .cmd(cmd)
	);

	sha_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .data_byte(data_byte),
		.sts(sts), .digest_word(digest_word)
	);
endmodule

@@ hw/rtl/sha_checker.sv @@
`include "sha256_stream_hasher_top_defines.svh"
module sha_checker (
	input logic clk,
	input logic arst_n,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [2:0] word_index,
	input logic last_word
);
	`SHA_ASSERT_IMPL(a_last_idx, out_valid, last_word == (word_index == 3'd7))
	`SHA_ASSERT_IMPL(a_no_overlap, out_valid, !in_ready)
	`SHA_ASSERT_NEXT(a_idx_step, out_valid && out_ready && !last_word,
		out_valid && word_index == $past(word_index) + 3'd1)
	`SHA_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(word_index))
endmodule

bind sha256_stream_hasher_top sha_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .word_index(word_index),
	.last_word(last_word)
);

@@ dv/sha256_stream_hasher_top_test.sv @@
`timescale 1ns / 1ps

module sha256_stream_hasher_top_test;
	import sha_pkg::*;

	typedef struct {
		logic [7:0] data_byte;
		logic has_byte;
		logic is_last;
	} byte_txn_t;

	typedef struct {
		logic [31:0] digest_word;
		logic [2:0] word_index;
		logic last_word;
	} digest_txn_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [7:0] data_byte = '0;
	logic has_byte = 1'b0;
	logic is_last = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [31:0] digest_word;
	logic [2:0] word_index;
	logic last_word;

	byte_txn_t pending_bytes[$];
	digest_txn_t expected_digests[$];
	int mismatch_count = 0;
	bit calm_phase = 1'b0;
	bit in_taken = 1'b0;
	int send_gap = 0;
	int recv_gap = 0;

	logic [31:0] hash_state [8];
	logic [7:0] msg_block [64];
	logic [5:0] block_fill;
	logic [63:0] msg_bits;

	sha256_stream_hasher_top dut (.*);

	always #5 clk = ~clk;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	task automatic compress_msg_block();
		logic [31:0] w [64];
		logic [31:0] v [8];
		logic [31:0] p, q, e, a;
		for (int r = 0; r < 16; r++)
			w[r] = {msg_block[4*r], msg_block[4*r+1], msg_block[4*r+2], msg_block[4*r+3]};
		for (int r = 16; r < 64; r++)
			w[r] = (rotr(w[r-2], 17) ^ rotr(w[r-2], 19) ^ (w[r-2] >> 10)) + w[r-7]
				+ (rotr(w[r-15], 7) ^ rotr(w[r-15], 18) ^ (w[r-15] >> 3)) + w[r-16];
		for (int r = 0; r < 8; r++)
			v[r] = hash_state[r];
		for (int r = 0; r < 64; r++) begin
			e = v[4];
			a = v[0];
			p = v[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & v[5]) ^ (~e & v[6]))
				+ ROUND_K[r] + w[r];
			q = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & v[1]) ^ (a & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + p;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = p + q;
		end
		for (int r = 0; r < 8; r++)
			hash_state[r] = hash_state[r] + v[r];
	endtask

	task automatic hash_restart();
		for (int r = 0; r < 8; r++)
			hash_state[r] = H_INIT[r];
		block_fill = '0;
		msg_bits = '0;
	endtask

	task automatic predict_digest(input byte_txn_t t);
		int pos;
		digest_txn_t d;
		if (t.has_byte) begin
			msg_block[block_fill] = t.data_byte;
			msg_bits = msg_bits + 64'd8;
			block_fill = block_fill + 6'd1;
			if (block_fill == 0)
				compress_msg_block();
		end
		if (!t.is_last)
			return;
		pos = block_fill;
		msg_block[pos] = PAD_BYTE;
		pos = pos + 1;
		if (pos > 56) begin
			while (pos < 64) begin
				msg_block[pos] = 8'h00;
				pos = pos + 1;
			end
			compress_msg_block();
			pos = 0;
		end
		while (pos < 56) begin
			msg_block[pos] = 8'h00;
			pos = pos + 1;
		end
		for (int i = 0; i < 8; i++)
			msg_block[56+i] = msg_bits[63-8*i -: 8];
		compress_msg_block();
		for (int i = 0; i < 8; i++) begin
			d.digest_word = hash_state[i];
			d.word_index = i[2:0];
			d.last_word = (i == 7);
			expected_digests.push_back(d);
		end
		hash_restart();
	endtask

	task automatic queue_byte(input logic [7:0] b, input logic hb, input logic last);
		byte_txn_t t;
		t.data_byte = b;
		t.has_byte = hb;
		t.is_last = last;
		pending_bytes.push_back(t);
	endtask

	task automatic queue_message(input int len);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 15) == 0)
				queue_byte(8'($urandom), 1'b0, 1'b0);
			queue_byte(8'($urandom), 1'b1, (i == len - 1) && $urandom_range(0, 1));
		end
		if (pending_bytes.size() == 0 || !pending_bytes[$].is_last)
			queue_byte(8'($urandom), 1'b0, 1'b1);
	endtask

	// driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (!(in_valid && !in_taken)) begin
				in_taken = 1'b0;
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					in_valid <= 1'b0;
				end else if (!calm_phase && $urandom_range(0, 7) == 0) begin
					send_gap <= $urandom_range(1, 13);
					in_valid <= 1'b0;
				end else if (pending_bytes.size() > 0) begin
					in_valid <= 1'b1;
					data_byte <= pending_bytes[0].data_byte;
					has_byte <= pending_bytes[0].has_byte;
					is_last <= pending_bytes[0].is_last;
				end else
					in_valid <= 1'b0;
			end
			if (recv_gap > 0) begin
				recv_gap <= recv_gap - 1;
				out_ready <= 1'b0;
			end else if (!calm_phase && $urandom_range(0, 7) == 0) begin
				recv_gap <= $urandom_range(1, 13);
				out_ready <= 1'b0;
			end else
				out_ready <= 1'b1;
		end
	end

	// monitor
	always @(posedge clk) begin
		digest_txn_t exp_d;
		if (arst_n && in_valid && in_ready) begin
			predict_digest(pending_bytes.pop_front());
			in_taken = 1'b1;
		end
		if (arst_n && out_valid && out_ready) begin
			if (expected_digests.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected digest transaction word=%h idx=%0d",
						digest_word, word_index);
			end else begin
				exp_d = expected_digests.pop_front();
				if (digest_word !== exp_d.digest_word || word_index !== exp_d.word_index ||
						last_word !== exp_d.last_word) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("digest mismatch exp %h/%0d/%b got %h/%0d/%b",
							exp_d.digest_word, exp_d.word_index, exp_d.last_word,
							digest_word, word_index, last_word);
				end
			end
		end
	end

	initial begin
		hash_restart();
		for (int i = 0; i < 64; i++)
			msg_block[i] = 8'h00;
		// directed: empty message, idle item, byte extremes
		queue_byte(8'h00, 1'b0, 1'b1);
		queue_byte(8'hff, 1'b0, 1'b0);
		queue_byte(8'hff, 1'b1, 1'b1);
		queue_byte(8'h00, 1'b1, 1'b0);
		queue_byte(8'hff, 1'b1, 1'b0);
		queue_byte(8'h00, 1'b0, 1'b1);
		// full block before padding, then pad spilling into an extra block
		queue_message(64);
		queue_message(56);
		repeat (5) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
		wait (pending_bytes.size() == 0);
		calm_phase = 1'b1;
		repeat (2) queue_message($urandom_range(0, 10));
		wait (pending_bytes.size() == 0 && !in_valid);
		wait (expected_digests.size() == 0);
		repeat (200) @(posedge clk);
		if (mismatch_count == 0 && expected_digests.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#2ms;
		$display("== FAIL ==");
		$finish;
	end
endmodule
